// ----- design/quaternion_to_euler_angles_core_defines.svh -----
// Assertion macros shared by the quaternion to Euler angle checker
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// Clocked assertion, off while reset is asserted
`define Q2E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signed bound check on a result field while a result is offered
`define Q2E_ASSERT_RANGE(lbl, sig, lim, msg) \
    `Q2E_ASSERT(lbl, out_valid |-> ((sig <= lim) && (sig >= -lim)), msg)

`endif

// ----- design/q2e_pkg.sv -----
// Shared types, widths, constants and helper functions of the quaternion to Euler angle core
`default_nettype none

package q2e_pkg;

    localparam int COMP_W    = 16;
    localparam int PROD_W    = 32;
    localparam int TERM_W    = 34;
    localparam int T_W       = 30;
    localparam int S_W       = 29;
    localparam int SQ_N_W    = 57;
    localparam int SQ_RES_W  = 59;
    localparam int SQ_STAGES = 29;
    localparam int CX_W      = 37;
    localparam int ANG_W     = 33;
    localparam int OUT_W     = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic signed [ANG_W-1:0]  HALF_PI_Q29 = 33'sd843314857;
    localparam logic signed [ANG_W-1:0]  PI_Q29      = 33'sd1686629713;
    localparam logic signed [TERM_W-1:0] ONE_Q28     = 34'sd268435456;
    localparam logic signed [17:0]       ANGLE_LIMIT = 18'sd25736;
    localparam logic [SQ_N_W-1:0]        SQ_ONE      = {1'b1, 56'd0};

    // Rotation sequence codes; even codes are Tait-Bryan, odd are proper Euler
    typedef enum logic [3:0] {
        SEQ_ZYX = 4'd0,
        SEQ_ZYZ = 4'd1,
        SEQ_ZXY = 4'd2,
        SEQ_ZXZ = 4'd3,
        SEQ_YXZ = 4'd4,
        SEQ_YXY = 4'd5,
        SEQ_YZX = 4'd6,
        SEQ_YZY = 4'd7,
        SEQ_XYZ = 4'd8,
        SEQ_XYX = 4'd9,
        SEQ_XZY = 4'd10,
        SEQ_XZX = 4'd11
    } seq_t;

    // One classified request: atan2 operand pairs already ordered for the back end
    typedef struct packed {
        logic signed [TERM_W-1:0] y0;
        logic signed [TERM_W-1:0] x0;
        logic signed [TERM_W-1:0] y2;
        logic signed [TERM_W-1:0] x2;
        logic signed [TERM_W-1:0] r21;
        logic                     proper;
        logic                     invalid;
    } q2e_entry_t;

    // Queue status seen by the two sides
    typedef struct packed {
        logic valid;
        logic full;
    } q2e_qstat_t;

    // round(atan(2^-i) * 2^29)
    function automatic logic signed [ANG_W-1:0] atan_q29(input int unsigned idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            0:  val = 33'sd421657428;
            1:  val = 33'sd248918915;
            2:  val = 33'sd131521918;
            3:  val = 33'sd66762579;
            4:  val = 33'sd33510843;
            5:  val = 33'sd16771758;
            6:  val = 33'sd8387925;
            7:  val = 33'sd4194219;
            8:  val = 33'sd2097141;
            9:  val = 33'sd1048575;
            10: val = 33'sd524288;
            11: val = 33'sd262144;
            12: val = 33'sd131072;
            13: val = 33'sd65536;
            14: val = 33'sd32768;
            15: val = 33'sd16384;
            16: val = 33'sd8192;
            17: val = 33'sd4096;
            18: val = 33'sd2048;
            19: val = 33'sd1024;
            20: val = 33'sd512;
            21: val = 33'sd256;
            22: val = 33'sd128;
            23: val = 33'sd64;
            24: val = 33'sd32;
            25: val = 33'sd16;
            26: val = 33'sd8;
            27: val = 33'sd4;
            28: val = 33'sd2;
            29: val = 33'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Q.29 angle to Q3.13 with rounding and clamp
    function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [ANG_W-1:0] ang);
        logic signed [ANG_W:0] sum;
        logic signed [17:0]    r;
        sum = {ang[ANG_W-1], ang} + 34'sd32768;
        r   = $signed(sum[ANG_W:16]);
        if (r > ANGLE_LIMIT)
        begin
            r = ANGLE_LIMIT;
        end
        else if (r < -ANGLE_LIMIT)
        begin
            r = -ANGLE_LIMIT;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/q2e_front.sv -----
// Front end: takes requests, forms products and matrix terms, picks operands per sequence
`default_nettype none

module q2e_front import q2e_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [COMP_W-1:0] comp_w,
    input  wire logic signed [COMP_W-1:0] comp_x,
    input  wire logic signed [COMP_W-1:0] comp_y,
    input  wire logic signed [COMP_W-1:0] comp_z,
    input  wire logic [3:0]               seq,
    input  wire q2e_qstat_t               qstat,
    output logic                          push,
    output q2e_entry_t                    entry
);

    logic adv;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [TERM_W-1:0] ta, tb, tc, td, te, tf, tp, tq, tr;
    logic signed [TERM_W-1:0] r11, r12, r21, r31, r32;
    logic                     bad_seq;
    q2e_entry_t               entry_next;
    q2e_entry_t               entry_reg;

    // Both front stages move together unless the queue blocks the last one
    assign adv      = !(s2_valid_reg && qstat.full);
    assign in_stall = !adv;
    assign push     = s2_valid_reg && !qstat.full;
    assign entry    = entry_reg;

    // Stage 1: component products
    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            ww_reg <= comp_w * comp_w;
            xx_reg <= comp_x * comp_x;
            yy_reg <= comp_y * comp_y;
            zz_reg <= comp_z * comp_z;
            xy_reg <= comp_x * comp_y;
            wz_reg <= comp_w * comp_z;
            xz_reg <= comp_x * comp_z;
            wy_reg <= comp_w * comp_y;
            yz_reg <= comp_y * comp_z;
            wx_reg <= comp_w * comp_x;
        end
    end

    // Matrix terms in Q.28
    always_comb
    begin
        ta = TERM_W'(xy_reg) + TERM_W'(wz_reg);
        tb = TERM_W'(xy_reg) - TERM_W'(wz_reg);
        tc = TERM_W'(xz_reg) + TERM_W'(wy_reg);
        td = TERM_W'(xz_reg) - TERM_W'(wy_reg);
        te = TERM_W'(yz_reg) + TERM_W'(wx_reg);
        tf = TERM_W'(yz_reg) - TERM_W'(wx_reg);
        ta = ta <<< 1;
        tb = tb <<< 1;
        tc = tc <<< 1;
        td = td <<< 1;
        te = te <<< 1;
        tf = tf <<< 1;
        tp = TERM_W'(ww_reg) + TERM_W'(xx_reg) - TERM_W'(yy_reg) - TERM_W'(zz_reg);
        tq = TERM_W'(ww_reg) - TERM_W'(xx_reg) + TERM_W'(yy_reg) - TERM_W'(zz_reg);
        tr = TERM_W'(ww_reg) - TERM_W'(xx_reg) - TERM_W'(yy_reg) + TERM_W'(zz_reg);
    end

    // Operand selection per rotation sequence
    always_comb
    begin
        bad_seq = 1'b0;
        r11     = '0;
        r12     = '0;
        r21     = '0;
        r31     = '0;
        r32     = '0;
        unique case (seq)
            SEQ_ZYX: begin r11 = ta;  r12 = tp;  r21 = -td; r31 = te;  r32 = tr;  end
            SEQ_ZYZ: begin r11 = tf;  r12 = tc;  r21 = tr;  r31 = te;  r32 = -td; end
            SEQ_ZXY: begin r11 = -tb; r12 = tq;  r21 = te;  r31 = -td; r32 = tr;  end
            SEQ_ZXZ: begin r11 = tc;  r12 = -tf; r21 = tr;  r31 = td;  r32 = te;  end
            SEQ_YXZ: begin r11 = tc;  r12 = tr;  r21 = -tf; r31 = ta;  r32 = tq;  end
            SEQ_YXY: begin r11 = tb;  r12 = te;  r21 = tq;  r31 = ta;  r32 = -tf; end
            SEQ_YZX: begin r11 = -td; r12 = tp;  r21 = ta;  r31 = -tf; r32 = tq;  end
            SEQ_YZY: begin r11 = te;  r12 = -tb; r21 = tq;  r31 = tf;  r32 = ta;  end
            SEQ_XYZ: begin r11 = -tf; r12 = tr;  r21 = tc;  r31 = -tb; r32 = tp;  end
            SEQ_XYX: begin r11 = ta;  r12 = -td; r21 = tp;  r31 = tb;  r32 = tc;  end
            SEQ_XZY: begin r11 = te;  r12 = tq;  r21 = -tb; r31 = tc;  r32 = tp;  end
            SEQ_XZX: begin r11 = td;  r12 = ta;  r21 = tp;  r31 = tc;  r32 = -tb; end
            default: bad_seq = 1'b1;
        endcase

        entry_next.proper  = seq[0];
        entry_next.invalid = bad_seq;
        entry_next.r21     = r21;
        // Tait-Bryan: first angle from (r31, r32); proper Euler: from (r11, r12)
        if (seq[0])
        begin
            entry_next.y0 = r11;
            entry_next.x0 = r12;
            entry_next.y2 = r31;
            entry_next.x2 = r32;
        end
        else
        begin
            entry_next.y0 = r31;
            entry_next.x0 = r32;
            entry_next.y2 = r11;
            entry_next.x2 = r12;
        end
    end

    // Stage 2: classified request
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ----- design/q2e_queue.sv -----
// Short request queue between front and back ends
`default_nettype none

module q2e_queue import q2e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire q2e_entry_t push_entry,
    input  wire logic       pop,
    output q2e_qstat_t      qstat,
    output q2e_entry_t      head
);

    q2e_entry_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && qstat.valid;
    assign head        = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/q2e_cordic.sv -----
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q.29, one iteration per stage
`default_nettype none

module q2e_cordic import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [CX_W-1:0] y_in,
    input  wire logic signed [CX_W-1:0] x_in,
    output logic signed [ANG_W-1:0]     ang_out
);

    logic signed [CX_W-1:0]  x_reg   [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]  y_reg   [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] ang_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]  x_next  [CORDIC_STEPS+1];
    logic signed [CX_W-1:0]  y_next  [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] ang_next[CORDIC_STEPS+1];

    assign ang_out = ang_reg[CORDIC_STEPS];

    always_comb
    begin
        // Quadrant pre-rotation; y of zero with negative x gives pi
        x_next[0]   = x_in;
        y_next[0]   = y_in;
        ang_next[0] = '0;
        if (y_in == '0)
        begin
            if (x_in < 0)
            begin
                ang_next[0] = PI_Q29;
            end
        end
        else if (x_in < 0)
        begin
            if (y_in > 0)
            begin
                x_next[0]   = y_in;
                y_next[0]   = -x_in;
                ang_next[0] = HALF_PI_Q29;
            end
            else
            begin
                x_next[0]   = -y_in;
                y_next[0]   = x_in;
                ang_next[0] = -HALF_PI_Q29;
            end
        end

        // One micro-rotation per stage, driven by the sign of y
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i+1]   = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] - (x_reg[i] >>> i);
                ang_next[i+1] = ang_reg[i] + atan_q29(i);
            end
            else if (y_reg[i] < 0)
            begin
                x_next[i+1]   = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1]   = y_reg[i] + (x_reg[i] >>> i);
                ang_next[i+1] = ang_reg[i] - atan_q29(i);
            end
            else
            begin
                x_next[i+1]   = x_reg[i];
                y_next[i+1]   = y_reg[i];
                ang_next[i+1] = ang_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/q2e_back.sv -----
// Back end: argument clamp, square-root pipeline, three CORDIC units, result register
`default_nettype none

module q2e_back import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire q2e_qstat_t          qstat,
    input  wire q2e_entry_t          head,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [OUT_W-1:0]  angle_first,
    output logic signed [OUT_W-1:0]  angle_second,
    output logic signed [OUT_W-1:0]  angle_third,
    output logic                     domain_clipped
);

    typedef struct packed {
        logic signed [TERM_W-1:0] y0;
        logic signed [TERM_W-1:0] x0;
        logic signed [TERM_W-1:0] y2;
        logic signed [TERM_W-1:0] x2;
        logic signed [T_W-1:0]    t;
        logic                     proper;
        logic                     invalid;
        logic                     clip;
    } side_t;

    typedef struct packed {
        logic invalid;
        logic clip;
    } flag_t;

    logic                     adv;
    side_t                    a_side_next;
    side_t                    a_side_reg;
    logic                     a_valid_reg;
    side_t                    b_side_reg;
    logic [SQ_N_W-1:0]        b_n_reg;
    logic                     b_valid_reg;
    logic signed [2*T_W-1:0]  tt;
    logic [SQ_STAGES-1:0]     sq_valid_reg;
    side_t                    sq_side_reg [SQ_STAGES];
    logic [SQ_N_W-1:0]        sq_n_reg    [SQ_STAGES];
    logic [SQ_RES_W-1:0]      sq_res_reg  [SQ_STAGES];
    logic [SQ_N_W-1:0]        sq_n_next   [SQ_STAGES];
    logic [SQ_RES_W-1:0]      sq_res_next [SQ_STAGES];
    side_t                    sq_last;
    logic [S_W-1:0]           s_val;
    logic signed [CX_W-1:0]   c1_t, c1_s, c1_y, c1_x;
    logic signed [ANG_W-1:0]  ang0, ang1, ang2;
    logic [CORDIC_STEPS:0]    c_valid_reg;
    flag_t                    c_flag_reg [CORDIC_STEPS+1];
    flag_t                    c_last;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  first_reg, second_reg, third_reg;
    logic                     clip_reg;

    // Whole back end moves when the result register can take a request
    assign adv            = !out_valid_reg || !out_stall;
    assign pop            = adv && qstat.valid;
    assign out_valid      = out_valid_reg;
    assign angle_first    = first_reg;
    assign angle_second   = second_reg;
    assign angle_third    = third_reg;
    assign domain_clipped = clip_reg;

    // Stage A: clamp the asin/acos argument to [-1, 1]
    always_comb
    begin
        a_side_next.y0      = head.y0;
        a_side_next.x0      = head.x0;
        a_side_next.y2      = head.y2;
        a_side_next.x2      = head.x2;
        a_side_next.proper  = head.proper;
        a_side_next.invalid = head.invalid;
        a_side_next.clip    = 1'b0;
        a_side_next.t       = head.r21[T_W-1:0];
        if (head.r21 > ONE_Q28)
        begin
            a_side_next.t    = ONE_Q28[T_W-1:0];
            a_side_next.clip = !head.invalid;
        end
        else if (head.r21 < -ONE_Q28)
        begin
            a_side_next.t    = -ONE_Q28[T_W-1:0];
            a_side_next.clip = !head.invalid;
        end
    end

    // Stage B: radicand 1 - t^2 in Q.56
    assign tt = a_side_reg.t * a_side_reg.t;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            b_n_reg    <= SQ_ONE - tt[SQ_N_W-1:0];
        end
    end

    // Square root, one result bit per stage
    always_comb
    begin
        logic [SQ_RES_W-1:0] n_in;
        logic [SQ_RES_W-1:0] res_in;
        logic [SQ_RES_W-1:0] bit_v;
        logic [SQ_RES_W-1:0] trial;
        logic [SQ_RES_W-1:0] diff;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            n_in   = (k == 0) ? {2'b00, b_n_reg} : {2'b00, sq_n_reg[(k == 0) ? 0 : k-1]};
            res_in = (k == 0) ? '0 : sq_res_reg[(k == 0) ? 0 : k-1];
            bit_v  = SQ_RES_W'(1) << (2 * (SQ_STAGES - 1 - k));
            trial  = res_in + bit_v;
            diff   = n_in - trial;
            if (n_in >= trial)
            begin
                sq_n_next[k]   = diff[SQ_N_W-1:0];
                sq_res_next[k] = (res_in >> 1) + bit_v;
            end
            else
            begin
                sq_n_next[k]   = n_in[SQ_N_W-1:0];
                sq_res_next[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_n_reg       <= sq_n_next;
            sq_res_reg     <= sq_res_next;
            sq_side_reg[0] <= b_side_reg;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    assign sq_last = sq_side_reg[SQ_STAGES-1];
    assign s_val   = sq_res_reg[SQ_STAGES-1][S_W-1:0];

    // Middle angle: asin(t) = atan2(t, s), acos(t) = atan2(s, t)
    assign c1_t = CX_W'(sq_last.t);
    assign c1_s = CX_W'($signed({1'b0, s_val}));
    assign c1_y = sq_last.proper ? c1_s : c1_t;
    assign c1_x = sq_last.proper ? c1_t : c1_s;

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic0
    (
        .clk     (clk),
        .en      (adv),
        .y_in    (CX_W'(sq_last.y0)),
        .x_in    (CX_W'(sq_last.x0)),
        .ang_out (ang0)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic1
    (
        .clk     (clk),
        .en      (adv),
        .y_in    (c1_y),
        .x_in    (c1_x),
        .ang_out (ang1)
    );

    q2e_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic2
    (
        .clk     (clk),
        .en      (adv),
        .y_in    (CX_W'(sq_last.y2)),
        .x_in    (CX_W'(sq_last.x2)),
        .ang_out (ang2)
    );

    // Flags ride alongside the CORDIC stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_flag_reg[0].invalid <= sq_last.invalid;
            c_flag_reg[0].clip    <= sq_last.clip;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                c_flag_reg[i] <= c_flag_reg[i-1];
            end
        end
    end

    assign c_last = c_flag_reg[CORDIC_STEPS];

    // Result register; unused sequence codes give zeros
    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg[CORDIC_STEPS])
        begin
            first_reg  <= c_last.invalid ? '0 : to_q13(ang0);
            second_reg <= c_last.invalid ? '0 : to_q13(ang1);
            third_reg  <= c_last.invalid ? '0 : to_q13(ang2);
            clip_reg   <= c_last.clip && !c_last.invalid;
        end
    end

    // Valid bits for every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            sq_valid_reg  <= '0;
            c_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= qstat.valid;
            b_valid_reg   <= a_valid_reg;
            sq_valid_reg  <= {sq_valid_reg[SQ_STAGES-2:0], b_valid_reg};
            c_valid_reg   <= {c_valid_reg[CORDIC_STEPS-1:0], sq_valid_reg[SQ_STAGES-1]};
            out_valid_reg <= c_valid_reg[CORDIC_STEPS];
        end
    end

endmodule

`default_nettype wire

// ----- design/quaternion_to_euler_angles_core.sv -----
// Top level of the quaternion to Euler angle core: sequence register, front, queue, back
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_stall  | comp_w, comp_x, comp_y, comp_z
//  output   | out_valid / out_stall| angle_first, angle_second, angle_third, domain_clipped
//  config   | cfg_wr_en            | cfg_wr_data (rotation sequence)
//
//  One request enters per cycle while in_stall is low; each request passes the
//  29-stage square-root pipeline and the CORDIC units.
//  Reset clears all valid bits, the queue and the sequence register (zyx).
//  An output stall freezes the back end; the front keeps taking requests until
//  the four-entry queue fills, then raises in_stall.
`default_nettype none

module quaternion_to_euler_angles_core import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [3:0]               cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [COMP_W-1:0] comp_w,
    input  wire logic signed [COMP_W-1:0] comp_x,
    input  wire logic signed [COMP_W-1:0] comp_y,
    input  wire logic signed [COMP_W-1:0] comp_z,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [OUT_W-1:0]       angle_first,
    output logic signed [OUT_W-1:0]       angle_second,
    output logic signed [OUT_W-1:0]       angle_third,
    output logic                          domain_clipped
);

    logic [3:0]  seq_reg;
    logic        push;
    logic        pop;
    q2e_entry_t  push_entry;
    q2e_entry_t  head;
    q2e_qstat_t  qstat;

    // Rotation sequence register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_ZYX;
        end
        else if (cfg_wr_en)
        begin
            seq_reg <= cfg_wr_data;
        end
    end

    q2e_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .comp_w   (comp_w),
        .comp_x   (comp_x),
        .comp_y   (comp_y),
        .comp_z   (comp_z),
        .seq      (seq_reg),
        .qstat    (qstat),
        .push     (push),
        .entry    (push_entry)
    );

    q2e_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .qstat      (qstat),
        .head       (head)
    );

    q2e_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .qstat          (qstat),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_first    (angle_first),
        .angle_second   (angle_second),
        .angle_third    (angle_third),
        .domain_clipped (domain_clipped)
    );

endmodule

`default_nettype wire

// ----- design/q2e_checker.sv -----
// Port-level checker for the quaternion to Euler angle core, bound to the top level
`default_nettype none

`include "quaternion_to_euler_angles_core_defines.svh"

module q2e_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [15:0] angle_first,
    input wire logic signed [15:0] angle_second,
    input wire logic signed [15:0] angle_third,
    input wire logic               domain_clipped
);

    // A stalled result stays offered and unchanged
    `Q2E_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
    `Q2E_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(angle_first) && $stable(angle_second) && $stable(angle_third) && $stable(domain_clipped), "result changed under stall")

    // First and third angles stay inside [-pi, pi] in Q3.13
    `Q2E_ASSERT_RANGE(a_first_range, angle_first, 16'sd25736, "angle_first out of range")
    `Q2E_ASSERT_RANGE(a_third_range, angle_third, 16'sd25736, "angle_third out of range")

endmodule

bind quaternion_to_euler_angles_core q2e_checker u_q2e_checker (.*);

`default_nettype wire
